### hdl/lsg_pkg.sv
`timescale 1ns / 1ps
package lsg_pkg;

   localparam int DELTA_WIDTH_DEF = 24;
   localparam int FIELD_WIDTH     = 24;
   localparam int PERIOD_WIDTH    = 32;
   localparam int NUM_AXES        = 5;
   localparam int REQ_DATA_WIDTH  = 152;
   localparam int RSP_DATA_WIDTH  = 48;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [1:0] STEP_NONE = 2'b00;
   localparam logic [1:0] STEP_FWD  = 2'b01;
   localparam logic [1:0] STEP_REV  = 2'b11;

   typedef struct packed {
      logic load;
      logic advance;
   } lane_ctrl_type;

   typedef struct packed {
      logic                    step_valid;
      logic [1:0]              step_x;
      logic [1:0]              step_y;
      logic [1:0]              step_z;
      logic [1:0]              step_a;
      logic [1:0]              step_b;
      logic [PERIOD_WIDTH-1:0] period;
      logic                    last;
   } rsp_type;

endpackage

### hdl/lsg_axis_lane.sv
`timescale 1ns / 1ps
module lsg_axis_lane #(
   parameter int DELTA_WIDTH = lsg_pkg::DELTA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lsg_pkg::lane_ctrl_type       ctrl,
   input  logic signed [DELTA_WIDTH-1:0] delta,
   input  logic [DELTA_WIDTH-1:0]       major_abs,
   output logic [DELTA_WIDTH-1:0]       load_abs,
   output logic [1:0]                   step
);

   localparam int ERR_WIDTH = DELTA_WIDTH + 2;

   logic [DELTA_WIDTH-1:0]      abs_ff, abs_in;
   logic                        neg_ff, neg_in;
   logic signed [ERR_WIDTH-1:0] err_ff, err_in;
   logic                        fire;
   logic signed [ERR_WIDTH-1:0] two_abs, two_major;

   assign load_abs  = delta[DELTA_WIDTH-1] ? (~delta + 1'b1) : delta;
   assign fire      = (err_ff > 0);
   assign two_abs   = $signed({1'b0, abs_ff, 1'b0});
   assign two_major = $signed({1'b0, major_abs, 1'b0});
   assign step      = fire ? (neg_ff ? lsg_pkg::STEP_REV : lsg_pkg::STEP_FWD)
                           : lsg_pkg::STEP_NONE;

   always_comb begin
      abs_in = abs_ff;
      neg_in = neg_ff;
      err_in = err_ff;
      if (ctrl.load) begin
         abs_in = load_abs;
         neg_in = delta[DELTA_WIDTH-1];
         err_in = $signed({1'b0, load_abs, 1'b0}) - $signed({2'b00, major_abs});
      end else if (ctrl.advance) begin
         // the major lane keeps its error at the major distance and fires every tick
         err_in = (fire ? (err_ff - two_major) : err_ff) + two_abs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_ff <= '0;
         neg_ff <= 1'b0;
         err_ff <= '0;
      end else begin
         abs_ff <= abs_in;
         neg_ff <= neg_in;
         err_ff <= err_in;
      end
   end

endmodule

### hdl/lsg_major_max.sv
`timescale 1ns / 1ps
module lsg_major_max #(
   parameter int DELTA_WIDTH = lsg_pkg::DELTA_WIDTH_DEF
) (
   input  logic [lsg_pkg::NUM_AXES-1:0][DELTA_WIDTH-1:0] lane_abs,
   output logic [DELTA_WIDTH-1:0]                        major_abs
);

   logic [DELTA_WIDTH-1:0] max_xy, max_za, max_xyza;

   // only the major distance matters, so ties need no resolving here
   assign max_xy    = (lane_abs[1] > lane_abs[0]) ? lane_abs[1] : lane_abs[0];
   assign max_za    = (lane_abs[3] > lane_abs[2]) ? lane_abs[3] : lane_abs[2];
   assign max_xyza  = (max_za > max_xy) ? max_za : max_xy;
   assign major_abs = (lane_abs[4] > max_xyza) ? lane_abs[4] : max_xyza;

endmodule

### hdl/lsg_skid_buffer.sv
`timescale 1ns / 1ps
module lsg_skid_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  lsg_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output lsg_pkg::rsp_type out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   lsg_pkg::rsp_type main_ff, main_in;
   lsg_pkg::rsp_type skid_ff, skid_in;
   logic             push, main_free;

   assign in_ready  = ~skid_valid_ff;
   assign push      = in_valid & ~skid_valid_ff;
   assign main_free = ~main_valid_ff | out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            // advance the parked beat
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

### hdl/five_axis_line_step_generator_unit.sv
`timescale 1ns / 1ps
// Five-axis line step generator.
// Input stream (req_): tuser selects the beat kind: 0 loads a move from the five
// signed deltas and the period in tdata, 1 asks for one step tick. A load replaces
// any active move. Every input beat yields exactly one output beat.
// Output stream (rsp_): tuser is step_valid, tdata holds the five 2-bit steps
// (-1, 0, +1) and the move period, tlast marks the final step of the move.
// Load beats, ticks while idle and zero-length moves give an all-zero beat.
// Five axis lanes keep distance, sign and error term; the major distance comes
// from a max tree over the lanes at load time. The move state updates in the
// cycle a beat is accepted, so one beat is taken every clock unless req_tready
// is low. Each result is registered in the output buffer before it reaches rsp_.
// Throughput: 1 beat per cycle. A two-entry output buffer takes beats while the
// receiver stalls; req_tready drops only once both entries are full.
// Reset clears the move (idle) and empties the output buffer.
module five_axis_line_step_generator_unit #(
   parameter int DELTA_WIDTH = lsg_pkg::DELTA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // delta_x, delta_y, delta_z, delta_a, delta_b, period_in
   input  logic [lsg_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // kind
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // step_x, step_y, step_z, step_a, step_b, period_out, zero pad
   output logic [lsg_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // step_valid
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int FW = lsg_pkg::FIELD_WIDTH;
   localparam int PW = lsg_pkg::PERIOD_WIDTH;
   localparam int NA = lsg_pkg::NUM_AXES;

   logic [DELTA_WIDTH-1:0] major_ff, major_in;
   logic [DELTA_WIDTH-1:0] steps_left_ff, steps_left_in;
   logic [PW-1:0]          period_ff, period_in;

   logic                               accept, do_load, do_tick;
   lsg_pkg::lane_ctrl_type             lane_ctrl;
   logic [NA-1:0][DELTA_WIDTH-1:0]     lane_abs;
   logic [NA-1:0][1:0]                 lane_step;
   logic [DELTA_WIDTH-1:0]             new_major, lane_major;
   lsg_pkg::rsp_type                   result, rsp_beat;

   assign accept  = req_tvalid & req_tready;
   assign do_load = accept & (req_tuser == lsg_pkg::KIND_LOAD);
   assign do_tick = accept & (req_tuser == lsg_pkg::KIND_TICK) & (steps_left_ff != '0);

   assign lane_ctrl.load    = do_load;
   assign lane_ctrl.advance = do_tick;
   assign lane_major        = do_load ? new_major : major_ff;

   for (genvar g = 0; g < NA; g++) begin : g_lane
      logic [FW+DELTA_WIDTH-1:0] field_ext;
      assign field_ext = {{DELTA_WIDTH{1'b0}}, req_tdata[g*FW +: FW]};

      lsg_axis_lane #(.DELTA_WIDTH(DELTA_WIDTH)) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .delta     ($signed(field_ext[DELTA_WIDTH-1:0])),
         .major_abs (lane_major),
         .load_abs  (lane_abs[g]),
         .step      (lane_step[g])
      );
   end

   lsg_major_max #(.DELTA_WIDTH(DELTA_WIDTH)) u_major (
      .lane_abs  (lane_abs),
      .major_abs (new_major)
   );

   always_comb begin
      major_in      = major_ff;
      steps_left_in = steps_left_ff;
      period_in     = period_ff;
      if (do_load) begin
         major_in      = new_major;
         steps_left_in = new_major;
         period_in     = req_tdata[NA*FW +: PW];
      end else if (do_tick) begin
         steps_left_in = steps_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff      <= '0;
         steps_left_ff <= '0;
         period_ff     <= '0;
      end else begin
         major_ff      <= major_in;
         steps_left_ff <= steps_left_in;
         period_ff     <= period_in;
      end
   end

   // merge lane steps into one beat; loads and idle ticks give all zeros
   always_comb begin
      result.step_valid = do_tick;
      result.step_x     = do_tick ? lane_step[0] : lsg_pkg::STEP_NONE;
      result.step_y     = do_tick ? lane_step[1] : lsg_pkg::STEP_NONE;
      result.step_z     = do_tick ? lane_step[2] : lsg_pkg::STEP_NONE;
      result.step_a     = do_tick ? lane_step[3] : lsg_pkg::STEP_NONE;
      result.step_b     = do_tick ? lane_step[4] : lsg_pkg::STEP_NONE;
      result.period     = do_tick ? period_ff : '0;
      result.last       = do_tick & (steps_left_ff == DELTA_WIDTH'(1));
   end

   lsg_skid_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_beat)
   );

   assign rsp_tdata = {6'b0, rsp_beat.period, rsp_beat.step_b, rsp_beat.step_a,
                       rsp_beat.step_z, rsp_beat.step_y, rsp_beat.step_x};
   assign rsp_tuser = rsp_beat.step_valid;
   assign rsp_tlast = rsp_beat.last;

endmodule

### hdl/lsg_checker.sv
`timescale 1ns / 1ps
module lsg_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [lsg_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lsg_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);

   logic unused_req;
   assign unused_req = req_tvalid & req_tready & req_tuser & (req_tdata != '0);

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled output beat changed");

   a_last_is_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("tlast on a beat without a step");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("non-step beat carries data");

   // at least one axis steps on every valid step beat, as the major axis always does
   a_major_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[9:0] != 10'd0)
      else $error("step beat with no axis moving");

endmodule

bind five_axis_line_step_generator_unit lsg_checker u_lsg_checker (.*);
